/* hw/rtl/tkh_pkg.sv */
// Shared types and constants of the triple-key indexed max-heap unit.
// No dependencies; imported by the top-level module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tkh_pkg;

	// Fixed widths of the register and of the item count on the result
	localparam int CFG_W     = 11;
	localparam int CNT_OUT_W = 11;
	localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

	// Request operation codes
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	// Result status codes
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// Heap identifiers
	localparam logic [1:0] HEAP_A = 2'd0;
	localparam logic [1:0] HEAP_B = 2'd1;
	localparam logic [1:0] HEAP_C = 2'd2;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE, ST_INS_RD, ST_INS_WR,
		ST_UP_TEST, ST_UP_KEY, ST_UP_CMP,
		ST_PLACE, ST_NEXT,
		ST_EX_RD0, ST_EX_SLOT, ST_EX_KEYS,
		ST_PL_RD, ST_PL_CHK,
		ST_LAST_RD, ST_LAST_KEY, ST_LAST_GO,
		ST_RM_PK, ST_RM_CMP,
		ST_DN_TEST, ST_DN_LK, ST_DN_LC, ST_DN_RK, ST_DN_RC, ST_DN_CMP,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

/* hw/rtl/tkh_if.sv */
// Channel interfaces of the triple-key heap unit: request, result, config.
// Depends on nothing; widths of the count and register are fixed.
`timescale 1ns / 1ps
`default_nettype none
interface tkh_cmd_if #(parameter int KEY_WIDTH = 32);
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [1:0]                  heap_select;
	logic signed [KEY_WIDTH-1:0] key_a;
	logic signed [KEY_WIDTH-1:0] key_b;
	logic signed [KEY_WIDTH-1:0] key_c;
	modport source (output valid, operation, heap_select, key_a, key_b, key_c, input ready);
	modport sink   (input valid, operation, heap_select, key_a, key_b, key_c, output ready);
endinterface

interface tkh_rsp_if #(parameter int KEY_WIDTH = 32);
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic signed [KEY_WIDTH-1:0] out_key_a;
	logic signed [KEY_WIDTH-1:0] out_key_b;
	logic signed [KEY_WIDTH-1:0] out_key_c;
	logic [10:0]                 items_held;
	modport source (output valid, status, out_key_a, out_key_b, out_key_c, items_held,
		input ready);
	modport sink   (input valid, status, out_key_a, out_key_b, out_key_c, items_held,
		output ready);
endinterface

interface tkh_cfg_if;
	logic        valid;
	logic        ready;
	logic [10:0] capacity_in_use;
	modport source (output valid, capacity_in_use, input ready);
	modport sink   (input valid, capacity_in_use, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tkh_ram.sv */
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tkh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/triple_key_indexed_max_heap_unit.sv */
// Top level of the triple-key indexed max-heap unit: sequencer and memories.
// Depends on tkh_pkg, tkh_if (interfaces) and tkh_ram.
//
//  channel | dir | handshake     | payload
//  cmd     | in  | valid/ready   | operation, heap_select, key_a, key_b, key_c
//  rsp     | out | valid/ready   | status, out_key_a/b/c, items_held
//  cfg     | in  | valid/ready   | capacity_in_use (ready always high)
//
// One request at a time. On the way up and on the way down, each heap level is
// an ordering RAM read, then a key RAM read, per node. A stalled result holds in
// the output register; the next request is still taken and waits at its end
// until that result has left.
// Reset clears control state only; no memory clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module triple_key_indexed_max_heap_unit
	import tkh_pkg::*;
#(
	parameter int MAX_ITEMS = 1024,
	parameter int KEY_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	tkh_cmd_if.sink   cmd,
	tkh_rsp_if.source rsp,
	tkh_cfg_if.sink   cfg
);
	localparam int AW   = $clog2(MAX_ITEMS);
	localparam int CW   = $clog2(MAX_ITEMS + 1);
	localparam int XW   = AW + 2;
	localparam int LIMW = ((CW > CFG_W) ? CW : CFG_W) + 1;
	localparam int KW   = KEY_WIDTH;

	state_t state_q, state_d;

	// request and progress registers
	logic                 op_q;
	logic [1:0]           sel_q;
	logic signed [KW-1:0] key_in_q [3];
	logic [1:0]           h_q;
	logic [2:0]           done_q;
	logic [AW-1:0]        k_q, s_q, slot_q, sp_q, sl_q, sb_q, big_q;
	logic signed [KW-1:0] kk_q, kl_q, kb_q;
	logic [CW-1:0]        count_q, hw_q;
	logic [CFG_W-1:0]     cap_q;

	// result register
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic signed [KW-1:0] oa_q, ob_q, oc_q;

	// memory ports
	logic              key_we;
	logic [AW-1:0]     key_waddr;
	logic [3*KW-1:0]   key_rdata;
	logic              ord_we;
	logic [AW+1:0]     ord_raddr;
	logic [AW-1:0]     ord_rdata;
	logic [AW-1:0]     wslot;
	logic [AW-1:0]     pl_rdata;
	logic              stk_we;
	logic [AW-1:0]     stk_rdata;

	// address arithmetic
	logic [CW-1:0]        last_w;
	logic [XW-1:0]        last_x, l_x, r_x;
	logic [AW-1:0]        parent_w;
	logic signed [KW-1:0] key_rd_h;
	logic                 full_w, ext_done_w;
	logic [1:0]           next_h;

	assign last_w   = count_q - CW'(1);
	assign last_x   = XW'(last_w);
	assign l_x      = {1'b0, k_q, 1'b1};
	assign r_x      = l_x + XW'(1);
	assign parent_w = (k_q - AW'(1)) >> 1;
	assign full_w   = LIMW'(count_q) >= ((LIMW'(cap_q) < LIMW'(MAX_ITEMS)) ?
		LIMW'(cap_q) : LIMW'(MAX_ITEMS));
	assign ext_done_w = &done_q;

	// key of the heap in work, from the key RAM
	always_comb begin
		case (h_q)
			HEAP_A:  key_rd_h = key_rdata[KW-1:0];
			HEAP_B:  key_rd_h = key_rdata[2*KW-1:KW];
			default: key_rd_h = key_rdata[3*KW-1:2*KW];
		endcase
	end

	// lowest heap not yet handled in an extract
	always_comb begin
		if (!done_q[0]) begin
			next_h = HEAP_A;
		end else if (!done_q[1]) begin
			next_h = HEAP_B;
		end else begin
			next_h = HEAP_C;
		end
	end

	// memories
	tkh_ram #(.WIDTH(3*KW), .DEPTH(MAX_ITEMS)) u_keys (
		.clk(clk), .we(key_we), .waddr(key_waddr),
		.wdata({key_in_q[2], key_in_q[1], key_in_q[0]}),
		.raddr(ord_rdata), .rdata(key_rdata)
	);
	tkh_ram #(.WIDTH(AW), .DEPTH(4*MAX_ITEMS)) u_order (
		.clk(clk), .we(ord_we), .waddr({h_q, k_q}), .wdata(wslot),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);
	tkh_ram #(.WIDTH(AW), .DEPTH(4*MAX_ITEMS)) u_place (
		.clk(clk), .we(ord_we), .waddr({h_q, wslot}), .wdata(k_q),
		.raddr({h_q, slot_q}), .rdata(pl_rdata)
	);
	tkh_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_free (
		.clk(clk), .we(stk_we), .waddr(last_w[AW-1:0]), .wdata(slot_q),
		.raddr(count_q[AW-1:0]), .rdata(stk_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					if (cmd.operation == OP_INSERT) begin
						state_d = full_w ? ST_FIN : ST_INS_RD;
					end else begin
						state_d = (count_q == '0) ? ST_FIN : ST_EX_RD0;
					end
				end
			end
			ST_INS_RD:   state_d = ST_INS_WR;
			ST_INS_WR:   state_d = ST_UP_TEST;
			ST_UP_TEST:  state_d = (k_q == '0) ? ST_PLACE : ST_UP_KEY;
			ST_UP_KEY:   state_d = ST_UP_CMP;
			ST_UP_CMP:   state_d = (key_rd_h < kk_q) ? ST_UP_TEST : ST_PLACE;
			ST_PLACE:    state_d = ST_NEXT;
			ST_NEXT: begin
				if (op_q == OP_INSERT) begin
					state_d = (h_q == HEAP_C) ? ST_FIN : ST_UP_TEST;
				end else begin
					state_d = ext_done_w ? ST_FIN : ST_PL_RD;
				end
			end
			ST_EX_RD0:   state_d = ST_EX_SLOT;
			ST_EX_SLOT:  state_d = ST_EX_KEYS;
			ST_EX_KEYS:  state_d = (last_w != '0) ? ST_LAST_RD : ST_NEXT;
			ST_PL_RD:    state_d = ST_PL_CHK;
			ST_PL_CHK:   state_d = (XW'(pl_rdata) >= last_x) ? ST_NEXT : ST_LAST_RD;
			ST_LAST_RD:  state_d = ST_LAST_KEY;
			ST_LAST_KEY: state_d = ST_LAST_GO;
			ST_LAST_GO:  state_d = (h_q == sel_q || k_q == '0) ? ST_DN_TEST : ST_RM_PK;
			ST_RM_PK:    state_d = ST_RM_CMP;
			ST_RM_CMP:   state_d = (kk_q > key_rd_h) ? ST_UP_TEST : ST_DN_TEST;
			ST_DN_TEST:  state_d = (l_x >= last_x) ? ST_PLACE : ST_DN_LK;
			ST_DN_LK:    state_d = ST_DN_LC;
			ST_DN_LC:    state_d = (r_x < last_x) ? ST_DN_RK : ST_DN_CMP;
			ST_DN_RK:    state_d = ST_DN_RC;
			ST_DN_RC:    state_d = ST_DN_CMP;
			ST_DN_CMP:   state_d = (kk_q < kb_q) ? ST_DN_TEST : ST_PLACE;
			ST_FIN:      state_d = (!out_valid_q || rsp.ready) ? ST_IDLE : ST_FIN;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory controls and handshakes
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		cfg.ready = 1'b1;
		key_we    = (state_q == ST_INS_WR);
		key_waddr = (count_q < hw_q) ? stk_rdata : count_q[AW-1:0];
		stk_we    = (state_q == ST_NEXT) && (op_q == OP_EXTRACT) && ext_done_w;
		ord_we    = 1'b0;
		wslot     = s_q;
		ord_raddr = {h_q, parent_w};
		case (state_q)
			ST_UP_CMP: begin
				ord_we = (key_rd_h < kk_q);
				wslot  = sp_q;
			end
			ST_DN_CMP: begin
				ord_we = (kk_q < kb_q);
				wslot  = sb_q;
			end
			ST_PLACE:   ord_we = 1'b1;
			ST_EX_RD0:  ord_raddr = {sel_q, {AW{1'b0}}};
			ST_LAST_RD: ord_raddr = {h_q, last_w[AW-1:0]};
			ST_DN_TEST: ord_raddr = {h_q, l_x[AW-1:0]};
			ST_DN_LC:   ord_raddr = {h_q, r_x[AW-1:0]};
			default:    ord_raddr = {h_q, parent_w};
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			hw_q        <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				cap_q <= cfg.capacity_in_use;
			end
			if (state_q == ST_FIN && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_NEXT && op_q == OP_INSERT && h_q == HEAP_C) begin
				count_q <= count_q + CW'(1);
				if (count_q >= hw_q) begin
					hw_q <= count_q + CW'(1);
				end
			end
			if (stk_we) begin
				count_q <= last_w;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q        <= cmd.operation;
				sel_q       <= (cmd.heap_select == 2'd3) ? HEAP_C : cmd.heap_select;
				key_in_q[0] <= cmd.key_a;
				key_in_q[1] <= cmd.key_b;
				key_in_q[2] <= cmd.key_c;
				oa_q        <= '0;
				ob_q        <= '0;
				oc_q        <= '0;
				status_q    <= (cmd.operation == OP_INSERT) ?
					(full_w ? STAT_FULL : STAT_DONE) :
					((count_q == '0) ? STAT_EMPTY : STAT_DONE);
			end
			ST_INS_WR: begin
				s_q  <= key_waddr;
				h_q  <= HEAP_A;
				k_q  <= count_q[AW-1:0];
				kk_q <= key_in_q[0];
			end
			ST_UP_KEY: sp_q <= ord_rdata;
			ST_UP_CMP: begin
				if (key_rd_h < kk_q) begin
					k_q <= parent_w;
				end
			end
			ST_NEXT: begin
				if (op_q == OP_INSERT) begin
					if (h_q != HEAP_C) begin
						h_q  <= h_q + 2'd1;
						k_q  <= count_q[AW-1:0];
						kk_q <= key_in_q[h_q + 2'd1];
					end
				end else if (!ext_done_w) begin
					h_q            <= next_h;
					done_q[next_h] <= 1'b1;
				end
			end
			ST_EX_SLOT: slot_q <= ord_rdata;
			ST_EX_KEYS: begin
				oa_q   <= key_rdata[KW-1:0];
				ob_q   <= key_rdata[2*KW-1:KW];
				oc_q   <= key_rdata[3*KW-1:2*KW];
				done_q <= 3'b001 << sel_q;
				h_q    <= sel_q;
				k_q    <= '0;
			end
			ST_PL_CHK:   k_q  <= pl_rdata;
			ST_LAST_KEY: s_q  <= ord_rdata;
			ST_LAST_GO:  kk_q <= key_rd_h;
			ST_DN_LK:    sl_q <= ord_rdata;
			ST_DN_LC: begin
				kl_q  <= key_rd_h;
				sb_q  <= sl_q;
				kb_q  <= key_rd_h;
				big_q <= l_x[AW-1:0];
			end
			ST_DN_RK: sp_q <= ord_rdata;
			ST_DN_RC: begin
				if (kl_q < key_rd_h) begin
					sb_q  <= sp_q;
					kb_q  <= key_rd_h;
					big_q <= r_x[AW-1:0];
				end
			end
			ST_DN_CMP: begin
				if (kk_q < kb_q) begin
					k_q <= big_q;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	logic [1:0]           rsp_status_q;
	logic signed [KW-1:0] rsp_a_q, rsp_b_q, rsp_c_q;
	logic [CNT_OUT_W-1:0] rsp_cnt_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!out_valid_q || rsp.ready)) begin
			rsp_status_q <= status_q;
			rsp_a_q      <= oa_q;
			rsp_b_q      <= ob_q;
			rsp_c_q      <= oc_q;
			rsp_cnt_q    <= CNT_OUT_W'(count_q);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.out_key_a  = rsp_a_q;
	assign rsp.out_key_b  = rsp_b_q;
	assign rsp.out_key_c  = rsp_c_q;
	assign rsp.items_held = rsp_cnt_q;
endmodule
`default_nettype wire
